### hdl/nfss_pkg.sv
package nfss_pkg;

    // Table geometry and field widths.
    localparam int SYMBOL_DEPTH = 1024;
    localparam int ADDR_W       = 32;
    localparam int IDX_W        = $clog2(SYMBOL_DEPTH);
    localparam int CNT_W        = $clog2(SYMBOL_DEPTH + 1);
    localparam int CFG_W        = 11;
    localparam int INFO_W       = 8;

    // ELF binding and type codes that the search cares about.
    localparam logic [3:0] BIND_GLOBAL = 4'd1;
    localparam logic [3:0] TYPE_FUNC   = 4'd2;

    // Request codes carried by the req_type field.
    typedef enum logic {
        REQ_LOAD   = 1'b0,
        REQ_SEARCH = 1'b1
    } t_req;

    // One stored symbol entry.
    typedef struct packed {
        logic [ADDR_W-1:0] value;
        logic [INFO_W-1:0] info;
        logic              named;
    } t_entry;

    // Search parameters latched at the start of a scan.
    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic              ext_only;
        logic [ADDR_W-1:0] max_dist;
    } t_query;

    // Result of one scan.
    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  index;
        logic [ADDR_W-1:0] value;
        logic [ADDR_W-1:0] distance;
    } t_result;

    // Status from the scan engine to the handshake logic.
    typedef struct packed {
        logic busy;
        logic done;
    } t_scan_stat;

    function automatic logic is_global(input logic [INFO_W-1:0] info);
        return info[7:4] == BIND_GLOBAL;
    endfunction

    function automatic logic is_func(input logic [INFO_W-1:0] info);
        return info[3:0] == TYPE_FUNC;
    endfunction

endpackage

### hdl/nearest_function_symbol_search_core.sv
// Nearest preceding function symbol search. A load beat writes one entry of
// a 1024-entry symbol table and returns no result. A search beat scans
// entries 0 to symbol_count-1 (at most 1024) and returns one beat with the
// closest named function symbol at or below the query address and within the
// starting distance bound. With the count capped at 1024, the next beat after
// a search is accepted once the scan has passed its done and idle states,
// provided the output register is free by then: the table has one read port,
// so one entry per cycle flows through a registered read and a single
// subtract-and-compare unit, and the result is then handed to the output
// register. The input is stalled for the whole search. The result sits in an
// output register, so a finished beat waiting on the output does not stop
// loads, and a following search stops only at its own end. The table has no
// reset; entries that a search reaches must have been loaded first.
module nearest_function_symbol_search_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [nfss_pkg::CFG_W-1:0]  i_cfg_wr_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_req_type,
    input  logic [nfss_pkg::IDX_W-1:0]  i_entry_index,
    input  logic [nfss_pkg::ADDR_W-1:0] i_entry_value,
    input  logic [nfss_pkg::INFO_W-1:0] i_entry_info,
    input  logic                        i_entry_named,
    input  logic [nfss_pkg::ADDR_W-1:0] i_query_address,
    input  logic                        i_query_external_only,
    input  logic [nfss_pkg::ADDR_W-1:0] i_query_max_distance,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_found,
    output logic [nfss_pkg::IDX_W-1:0]  o_symbol_index,
    output logic [nfss_pkg::ADDR_W-1:0] o_symbol_value,
    output logic [nfss_pkg::ADDR_W-1:0] o_distance
);
    import nfss_pkg::*;

    logic [CFG_W-1:0] r_symbol_count;
    logic             r_out_valid;
    t_result          r_out;

    logic             w_in_acc;
    logic             w_wr_en;
    logic             w_start;
    logic             w_ack;
    t_entry           w_entry;
    t_query           w_query;
    t_scan_stat       w_stat;
    t_result          w_result;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_symbol_count <= '0;
        end else if (i_cfg_wr_en) begin
            r_symbol_count <= i_cfg_wr_data;
        end
    end

    // Input beat decode.
    assign o_in_stall = w_stat.busy;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_wr_en    = w_in_acc && (t_req'(i_req_type) == REQ_LOAD)
                        && (int'(i_entry_index) < SYMBOL_DEPTH);
    assign w_start    = w_in_acc && (t_req'(i_req_type) == REQ_SEARCH);

    assign w_entry.value     = i_entry_value;
    assign w_entry.info      = i_entry_info;
    assign w_entry.named     = i_entry_named;
    assign w_query.address   = i_query_address;
    assign w_query.ext_only  = i_query_external_only;
    assign w_query.max_dist  = i_query_max_distance;

    nfss_scan u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (w_wr_en),
        .i_wr_idx   (i_entry_index),
        .i_wr_entry (w_entry),
        .i_start    (w_start),
        .i_query    (w_query),
        .i_count    (r_symbol_count),
        .i_ack      (w_ack),
        .o_stat     (w_stat),
        .o_result   (w_result)
    );

    // Output register: take a finished scan whenever the register is free or draining.
    assign w_ack = w_stat.done && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ack) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ack) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_found        = r_out.found;
    assign o_symbol_index = r_out.index;
    assign o_symbol_value = r_out.value;
    assign o_distance     = r_out.distance;

    // A beat with nothing found carries zero index and zero value.
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_symbol_index == '0 && o_symbol_value == '0))
        else $error("empty result carries a nonzero index or value");

    // A finished scan always lands in the output register.
    a_ack_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ack |=> o_out_valid)
        else $error("finished scan did not reach the output");

    // A search keeps the input stalled on the following cycle.
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> (o_in_stall && !w_stat.done))
        else $error("scan did not start after a search beat");

endmodule

### hdl/nfss_scan.sv
module nfss_scan (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_wr_en,
    input  logic [nfss_pkg::IDX_W-1:0] i_wr_idx,
    input  nfss_pkg::t_entry          i_wr_entry,
    input  logic                      i_start,
    input  nfss_pkg::t_query          i_query,
    input  logic [nfss_pkg::CFG_W-1:0] i_count,
    input  logic                      i_ack,
    output nfss_pkg::t_scan_stat      o_stat,
    output nfss_pkg::t_result         o_result
);
    import nfss_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_scan_state;

    t_scan_state       r_state, n_state;
    t_entry            r_mem [SYMBOL_DEPTH];
    t_entry            r_rd_data;
    logic [CNT_W-1:0]  r_rd_idx;
    logic [CNT_W-1:0]  r_count;
    logic              r_cmp_vld;
    logic [IDX_W-1:0]  r_cmp_idx;
    t_query            r_query;
    logic [ADDR_W-1:0] r_bound;
    logic              r_have;
    logic [IDX_W-1:0]  r_best_idx;
    logic [ADDR_W-1:0] r_best_val;
    logic              r_best_glb;

    logic              w_rd_more;
    logic [ADDR_W:0]   w_diff;
    logic [ADDR_W-1:0] w_dist;
    logic              w_glb;
    logic              w_qual;
    logic              w_take;

    // Symbol table: one write port for loads, one registered read port for the scan.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_entry;
        end
        r_rd_data <= r_mem[r_rd_idx[IDX_W-1:0]];
    end

    assign w_rd_more = r_rd_idx < r_count;

    // Shared compare unit: one entry per cycle against the running bound.
    always_comb begin
        w_diff = {1'b0, r_query.address} - {1'b0, r_rd_data.value};
        w_dist = w_diff[ADDR_W-1:0];
        w_glb  = is_global(r_rd_data.info);
        w_qual = r_cmp_vld && r_rd_data.named && (!r_query.ext_only || w_glb)
                 && !w_diff[ADDR_W] && is_func(r_rd_data.info);
        w_take = w_qual && ((w_dist < r_bound) ||
                 ((w_dist == r_bound) && (!r_have || (!r_best_glb && w_glb))));
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!w_rd_more && !r_cmp_vld) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_ack) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cmp_vld <= 1'b0;
            r_rd_idx  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE) begin
                r_cmp_vld <= 1'b0;
                r_rd_idx  <= '0;
            end else if (r_state == S_SCAN) begin
                r_cmp_vld <= w_rd_more;
                if (w_rd_more) begin
                    r_rd_idx <= r_rd_idx + 1'b1;
                end
            end
        end
    end

    // Scan data path: query capture and best-so-far tracking.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_query    <= i_query;
            r_bound    <= i_query.max_dist;
            r_have     <= 1'b0;
            r_best_idx <= '0;
            r_best_val <= '0;
            r_best_glb <= 1'b0;
            r_count    <= (i_count > CFG_W'(SYMBOL_DEPTH)) ? CNT_W'(SYMBOL_DEPTH)
                                                           : CNT_W'(i_count);
        end else if (r_state == S_SCAN) begin
            r_cmp_idx <= r_rd_idx[IDX_W-1:0];
            if (w_take) begin
                r_bound    <= w_dist;
                r_have     <= 1'b1;
                r_best_idx <= r_cmp_idx;
                r_best_val <= r_rd_data.value;
                r_best_glb <= w_glb;
            end
        end
    end

    assign o_stat.busy = (r_state != S_IDLE);
    assign o_stat.done = (r_state == S_DONE);

    assign o_result.found    = r_have;
    assign o_result.index    = r_have ? r_best_idx : '0;
    assign o_result.value    = r_have ? r_best_val : '0;
    assign o_result.distance = r_have ? r_bound : r_query.address;

endmodule

### bench/nearest_function_symbol_search_core_test.sv
module nearest_function_symbol_search_core_test;
    import nfss_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD     = 400;
    localparam int FILL_SLOTS    = 256;
    localparam logic [ADDR_W-1:0] VALUE_BASE = 32'h4000_0000;

    // One input beat as the sender sees it.
    typedef struct {
        t_req             req;
        logic [IDX_W-1:0] slot;
        t_entry           entry;
        t_query           query;
    } t_beat;

    // Directed rows: a beat to send, or a new symbol count to program.
    typedef enum logic {
        ROW_BEAT  = 1'b0,
        ROW_COUNT = 1'b1
    } t_row_kind;

    typedef struct {
        t_row_kind        kind;
        logic [CFG_W-1:0] count;
        t_beat            beat;
        logic             known;
        t_result          want;
    } t_row;

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [CFG_W-1:0]  cfg_wr_data;
    logic              in_valid;
    logic              in_stall;
    logic              req_type;
    logic [IDX_W-1:0]  entry_index;
    logic [ADDR_W-1:0] entry_value;
    logic [INFO_W-1:0] entry_info;
    logic              entry_named;
    logic [ADDR_W-1:0] query_address;
    logic              query_external_only;
    logic [ADDR_W-1:0] query_max_distance;
    logic              out_valid;
    logic              out_stall;
    logic              found;
    logic [IDX_W-1:0]  symbol_index;
    logic [ADDR_W-1:0] symbol_value;
    logic [ADDR_W-1:0] distance;

    // Shadow copy of the symbol table and the count register.
    logic [ADDR_W-1:0] sym_value [SYMBOL_DEPTH];
    logic [INFO_W-1:0] sym_info [SYMBOL_DEPTH];
    logic              sym_named [SYMBOL_DEPTH];
    logic [CFG_W-1:0]  scan_count;

    t_result predicted_lookups [$];
    int      mismatches;
    bit      calm;
    bit      hold_req;

    nearest_function_symbol_search_core dut (
        .i_clk                 (clk),
        .i_rst_n               (rst_n),
        .i_cfg_wr_en           (cfg_wr_en),
        .i_cfg_wr_data         (cfg_wr_data),
        .i_in_valid            (in_valid),
        .o_in_stall            (in_stall),
        .i_req_type            (req_type),
        .i_entry_index         (entry_index),
        .i_entry_value         (entry_value),
        .i_entry_info          (entry_info),
        .i_entry_named         (entry_named),
        .i_query_address       (query_address),
        .i_query_external_only (query_external_only),
        .i_query_max_distance  (query_max_distance),
        .o_out_valid           (out_valid),
        .i_out_stall           (out_stall),
        .o_found               (found),
        .o_symbol_index        (symbol_index),
        .o_symbol_value        (symbol_value),
        .o_distance            (distance)
    );

    // Free-running clock.
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Closest named function symbol at or below the address, within the bound.
    function automatic t_result nearest_symbol(input logic [ADDR_W-1:0] addr,
                                               input logic ext_only,
                                               input logic [ADDR_W-1:0] max_dist);
        t_result           res;
        logic [ADDR_W-1:0] bound;
        logic [ADDR_W-1:0] d;
        logic              have;
        logic              cand;
        int                best;
        int                span;
        bound = max_dist;
        have  = 1'b0;
        best  = 0;
        span  = (scan_count > SYMBOL_DEPTH) ? SYMBOL_DEPTH : int'(scan_count);
        for (int i = 0; i < span; i++) begin
            cand = sym_named[i] && !(ext_only && sym_info[i][7:4] != BIND_GLOBAL) &&
                   addr >= sym_value[i] && sym_info[i][3:0] == TYPE_FUNC;
            if (cand) begin
                d = addr - sym_value[i];
                if (d < bound) begin
                    bound = d;
                    best  = i;
                    have  = 1'b1;
                end else if (d == bound) begin
                    // A global entry wins a tie against a non-global one.
                    if (!have) begin
                        best = i;
                        have = 1'b1;
                    end else if (sym_info[best][7:4] != BIND_GLOBAL &&
                                 sym_info[i][7:4] == BIND_GLOBAL) begin
                        best = i;
                    end
                end
            end
        end
        res.found    = have;
        res.index    = have ? IDX_W'(best) : '0;
        res.value    = have ? sym_value[best] : '0;
        res.distance = have ? bound : addr;
        return res;
    endfunction

    function automatic t_result outcome(input logic f, input logic [IDX_W-1:0] idx,
                                        input logic [ADDR_W-1:0] val,
                                        input logic [ADDR_W-1:0] dist_val);
        t_result res;
        res.found    = f;
        res.index    = idx;
        res.value    = val;
        res.distance = dist_val;
        return res;
    endfunction

    function automatic t_row load_row(input logic [IDX_W-1:0] slot,
                                      input logic [ADDR_W-1:0] value,
                                      input logic [INFO_W-1:0] info, input logic named);
        t_row r;
        r.kind        = ROW_BEAT;
        r.count       = '0;
        r.beat.req    = REQ_LOAD;
        r.beat.slot   = slot;
        r.beat.entry  = '{value: value, info: info, named: named};
        r.beat.query  = '0;
        r.known       = 1'b0;
        r.want        = '0;
        return r;
    endfunction

    function automatic t_row search_row(input logic [ADDR_W-1:0] addr, input logic ext,
                                        input logic [ADDR_W-1:0] max_dist,
                                        input logic known, input t_result want);
        t_row r;
        r.kind        = ROW_BEAT;
        r.count       = '0;
        r.beat.req    = REQ_SEARCH;
        r.beat.slot   = '0;
        r.beat.entry  = '0;
        r.beat.query  = '{address: addr, ext_only: ext, max_dist: max_dist};
        r.known       = known;
        r.want        = want;
        return r;
    endfunction

    function automatic t_row count_row(input logic [CFG_W-1:0] c);
        t_row r;
        r.kind  = ROW_COUNT;
        r.count = c;
        r.beat  = '{REQ_LOAD, '0, '0, '0};
        r.known = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    function automatic int draw_wait();
        return calm ? 0 : int'($urandom_range(0, 11));
    endfunction

    // Mostly clustered values so that searches find close neighbors.
    function automatic t_entry random_entry();
        t_entry     e;
        logic [3:0] bind_code;
        logic [3:0] type_code;
        e.value = ($urandom_range(0, 9) == 0) ? $urandom :
                  VALUE_BASE + $urandom_range(0, 'hFFFF);
        case ($urandom_range(0, 3))
            0:       bind_code = 4'd0;
            1, 2:    bind_code = BIND_GLOBAL;
            default: bind_code = 4'($urandom_range(0, 15));
        endcase
        type_code = ($urandom_range(0, 3) != 0) ? TYPE_FUNC : 4'($urandom_range(0, 15));
        e.info  = {bind_code, type_code};
        e.named = ($urandom_range(0, 7) != 0);
        return e;
    endfunction

    // Random beat aimed at the scanned part of the table.
    function automatic t_beat random_beat();
        t_beat             b;
        int                span;
        int                j;
        logic [ADDR_W-1:0] near;
        span = (scan_count > SYMBOL_DEPTH) ? SYMBOL_DEPTH : int'(scan_count);
        j    = (span == 0) ? $urandom_range(0, FILL_SLOTS - 1) : $urandom_range(0, span - 1);
        b.req   = ($urandom_range(0, 9) < 3) ? REQ_LOAD : REQ_SEARCH;
        b.slot  = ($urandom_range(0, 9) < 7) ? IDX_W'(j) : IDX_W'($urandom);
        b.entry = random_entry();
        // Copy a neighbor's value now and then to set up distance ties.
        if (span != 0 && $urandom_range(0, 3) == 0)
            b.entry.value = sym_value[$urandom_range(0, span - 1)];
        near = sym_value[j] + $urandom_range(0, 4095);
        b.query.address  = ($urandom_range(0, 4) == 0) ? $urandom : near;
        b.query.ext_only = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 5))
            0, 1:    b.query.max_dist = '1;
            2:       b.query.max_dist = $urandom_range(0, 8192);
            3:       b.query.max_dist = b.query.address - sym_value[j];
            4:       b.query.max_dist = $urandom;
            default: b.query.max_dist = '0;
        endcase
        return b;
    endfunction

    // Offer one beat after a random gap and record its effect once accepted.
    task automatic send_beat(input t_beat b, input logic known, input t_result want);
        int gap;
        gap = draw_wait();
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid            <= 1'b1;
        req_type            <= b.req;
        entry_index         <= b.slot;
        entry_value         <= b.entry.value;
        entry_info          <= b.entry.info;
        entry_named         <= b.entry.named;
        query_address       <= b.query.address;
        query_external_only <= b.query.ext_only;
        query_max_distance  <= b.query.max_dist;
        do @(posedge clk); while (in_stall !== 1'b0);
        if (b.req == REQ_LOAD) begin
            sym_value[b.slot] = b.entry.value;
            sym_info[b.slot]  = b.entry.info;
            sym_named[b.slot] = b.entry.named;
        end else if (known) begin
            predicted_lookups.push_back(want);
        end else begin
            predicted_lookups.push_back(nearest_symbol(b.query.address, b.query.ext_only,
                                                       b.query.max_dist));
        end
    endtask

    // Wait until the block has drained and gone quiet.
    task automatic settle();
        in_valid <= 1'b0;
        while (predicted_lookups.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_count(input logic [CFG_W-1:0] c);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= c;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        scan_count  = c;
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] c, input int n_beats,
                             input bit quiet, input bit squeeze);
        settle();
        set_count(c);
        calm     = quiet;
        hold_req = squeeze;
        repeat (n_beats) send_beat(random_beat(), 1'b0, '0);
    endtask

    task automatic compare_field(input string name, input logic [ADDR_W-1:0] want,
                                 input logic [ADDR_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Result side: random stalls, one long hold-off on request, field checks.
    initial begin : receiver
        int      hold;
        t_result want;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            hold = draw_wait();
            if (hold_req) begin
                hold     = LONG_HOLD;
                hold_req = 1'b0;
            end
            if (hold != 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
            if (predicted_lookups.size() == 0) begin
                $error("result beat arrived with no search pending");
                mismatches++;
            end else begin
                want = predicted_lookups.pop_front();
                compare_field("found", ADDR_W'(want.found), ADDR_W'(found));
                compare_field("symbol_index", ADDR_W'(want.index), ADDR_W'(symbol_index));
                compare_field("symbol_value", want.value, symbol_value);
                compare_field("distance", want.distance, distance);
            end
        end
    end

    // Give up if the run hangs.
    initial begin : watchdog
        int cycles;
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Reset, directed rows, table preload, random phases, final verdict.
    initial begin : stimulus
        t_row  plan [$];
        t_beat b;
        mismatches          = 0;
        calm                = 1'b0;
        hold_req            = 1'b0;
        scan_count          = '0;
        rst_n               <= 1'b0;
        cfg_wr_en           <= 1'b0;
        cfg_wr_data         <= '0;
        in_valid            <= 1'b0;
        req_type            <= REQ_LOAD;
        entry_index         <= '0;
        entry_value         <= '0;
        entry_info          <= '0;
        entry_named         <= 1'b0;
        query_address       <= '0;
        query_external_only <= 1'b0;
        query_max_distance  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With a count of zero after reset nothing is ever found.
        plan.push_back(search_row('1, 1'b0, '1, 1'b1, outcome(1'b0, '0, '0, '1)));
        plan.push_back(search_row('0, 1'b0, '0, 1'b1, outcome(1'b0, '0, '0, '0)));
        // Global and local functions sharing values, an object, an unnamed
        // entry, a weak function at the top of the address space.
        plan.push_back(load_row(10'd0, 32'h0000_0000, 8'h12, 1'b1));
        plan.push_back(load_row(10'd1, 32'h0000_1000, 8'h02, 1'b1));
        plan.push_back(load_row(10'd2, 32'h0000_1000, 8'h12, 1'b1));
        plan.push_back(load_row(10'd3, 32'h0000_2000, 8'h11, 1'b1));
        plan.push_back(load_row(10'd4, 32'h0000_2000, 8'h12, 1'b0));
        plan.push_back(load_row(10'd5, 32'hFFFF_FFFF, 8'h22, 1'b1));
        plan.push_back(load_row(10'd6, 32'h0000_1800, 8'h02, 1'b1));
        plan.push_back(load_row(10'd7, 32'h0000_1800, 8'hF2, 1'b1));
        plan.push_back(count_row(CFG_W'(8)));
        // Tie at zero distance: the global entry replaces the local one.
        plan.push_back(search_row(32'h1000, 1'b0, '1, 1'b1,
                                  outcome(1'b1, 10'd2, 32'h1000, 32'd0)));
        // External only skips locals, weak and odd bindings.
        plan.push_back(search_row(32'h1800, 1'b1, '1, 1'b1,
                                  outcome(1'b1, 10'd2, 32'h1000, 32'h800)));
        // Tie between two non-global entries keeps the first.
        plan.push_back(search_row(32'h1900, 1'b0, '1, 1'b1,
                                  outcome(1'b1, 10'd6, 32'h1800, 32'h100)));
        plan.push_back(search_row('1, 1'b0, '1, 1'b1, outcome(1'b1, 10'd5, '1, '0)));
        // A zero bound still admits an exact hit.
        plan.push_back(search_row(32'h1000, 1'b0, '0, 1'b1,
                                  outcome(1'b1, 10'd2, 32'h1000, '0)));
        // Distance equal to the starting bound qualifies; one above does not.
        plan.push_back(search_row(32'h1500, 1'b0, 32'h500, 1'b1,
                                  outcome(1'b1, 10'd2, 32'h1000, 32'h500)));
        plan.push_back(search_row(32'h1500, 1'b0, 32'h4FF, 1'b1,
                                  outcome(1'b0, '0, '0, 32'h1500)));
        plan.push_back(search_row('0, 1'b0, '1, 1'b1, outcome(1'b1, '0, '0, '0)));
        plan.push_back(search_row(32'h2100, 1'b0, '1, 1'b0, '0));
        plan.push_back(search_row(32'h2100, 1'b1, '1, 1'b0, '0));
        plan.push_back(count_row(CFG_W'(1)));
        plan.push_back(search_row(32'h1000, 1'b0, '1, 1'b1,
                                  outcome(1'b1, '0, '0, 32'h1000)));

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_COUNT) begin
                settle();
                set_count(plan[i].count);
            end else begin
                send_beat(plan[i].beat, plan[i].known, plan[i].want);
            end
        end

        // Fill the low part of the table back to back; later scans stay inside it.
        settle();
        calm = 1'b1;
        for (int i = 0; i < FILL_SLOTS; i++) begin
            b       = random_beat();
            b.req   = REQ_LOAD;
            b.slot  = IDX_W'(i);
            b.entry = random_entry();
            send_beat(b, 1'b0, '0);
        end

        // Random phases over small and larger scan counts within the filled slots.
        run_phase(CFG_W'(4), 40, 1'b0, 1'b0);
        run_phase(CFG_W'(1), 20, 1'b0, 1'b0);
        run_phase(CFG_W'(16), 50, 1'b1, 1'b0);
        run_phase(CFG_W'(64), 50, 1'b0, 1'b1);
        run_phase(CFG_W'(0), 15, 1'b0, 1'b0);
        run_phase(CFG_W'(200), 30, 1'b0, 1'b0);
        run_phase(CFG_W'(FILL_SLOTS), 10, 1'b0, 1'b0);
        run_phase(CFG_W'(32), 45, 1'b0, 1'b0);
        run_phase(CFG_W'(8), 40, 1'b0, 1'b0);
        settle();

        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
